[rtl/r250_pkg.sv]
// r250_pkg: shared constants and types for the r250 random generator
// no dependencies; imported by r250_ram users and the core
package r250_pkg;

  localparam int unsigned TableDepth = 250;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned DiagCount  = 32;
  localparam int unsigned DiagW      = 5;

  localparam logic [IdxW-1:0] LastIdx  = 8'd249;
  localparam logic [IdxW-1:0] LagShort = 8'd103;
  localparam logic [IdxW-1:0] LagWrap  = 8'd147;
  localparam logic [IdxW-1:0] DiagOffset = 8'd3;
  localparam logic [DiagW-1:0] LastDiag  = 5'd31;

  localparam logic [WordBits-1:0] LcgMul       = 32'd1664525;
  localparam logic [WordBits-1:0] LcgAdd       = 32'd1013904223;
  localparam logic [WordBits-1:0] MsbThreshold = 32'h4000_0000;
  localparam logic [WordBits-1:0] TopBit       = 32'h8000_0000;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [WordBits-1:0] word_t;

endpackage

[rtl/r250_ram.sv]
// r250_ram: generic synchronous ram, one write port and two registered read ports
// standalone, no package dependency
module r250_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[rtl/r250_random_generator_core.sv]
// r250 lagged-fibonacci xor generator (lags 250/103), command interface.
// A draw transfer (mode_i low) is accepted when start is high and busy is low; its
// word appears on random_value_o with valid_o high for one cycle, the cycle after
// acceptance, and busy stays high for that cycle, so no new draw is accepted in it:
// the table sits in a ram with registered reads, read in the accepting cycle and
// written back in the strobe cycle. A reseed (mode_i high) produces no result and
// holds busy through 250 fill writes, 250 read-modify-write steps setting msbs,
// 32 diagonal fix steps and one final write, all through the single ram write
// port. The receiver cannot stall; each result must be taken in its strobe cycle.
// Draws before the first reseed return undefined words.
// depends on r250_pkg and r250_ram
module r250_random_generator_core
  import r250_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [31:0] seed_value_i,
  output logic        valid_o,
  output logic [31:0] random_value_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDraw  = 6'b000010,
    StFill  = 6'b000100,
    StMix   = 6'b001000,
    StDiag  = 6'b010000,
    StDrain = 6'b100000
  } state_e;

  state_e state_q, state_d;
  idx_t   pos_q, pos_d;
  idx_t   cnt_q, cnt_d;
  word_t  lcg_q, lcg_d;

  // read-modify-write stage for the reseed passes
  logic   wb_vld_q, wb_vld_d;
  idx_t   wb_addr_q, wb_addr_d;
  word_t  wb_and_q, wb_and_d;
  word_t  wb_or_q, wb_or_d;

  logic   accept;
  word_t  lcg_next;
  idx_t   partner;
  idx_t   diag_addr;
  logic [DiagW-1:0] diag_j;

  logic   we;
  idx_t   waddr, raddr_a;
  word_t  wdata, rdata_a, rdata_b;
  word_t  draw_word;

  assign accept    = start && !busy;
  assign lcg_next  = 32'(lcg_q * LcgMul + LcgAdd);
  assign partner   = (pos_q >= LagWrap) ? idx_t'(pos_q - LagWrap) : idx_t'(pos_q + LagShort);
  assign diag_j    = cnt_q[DiagW-1:0];
  // 7*j + 3 as 8*j - j + 3
  assign diag_addr = idx_t'({cnt_q[IdxW-4:0], 3'b000} - cnt_q + DiagOffset);
  assign draw_word = rdata_a ^ rdata_b;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    lcg_d     = lcg_q;
    wb_vld_d  = 1'b0;
    wb_addr_d = wb_addr_q;
    wb_and_d  = wb_and_q;
    wb_or_d   = wb_or_q;
    raddr_a   = pos_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (mode_i) begin
            state_d = StFill;
            lcg_d   = seed_value_i;
            cnt_d   = '0;
            pos_d   = '0;
          end else begin
            state_d = StDraw;
          end
        end
      end
      StDraw: begin
        pos_d   = (pos_q == LastIdx) ? '0 : idx_t'(pos_q + 1'b1);
        state_d = StIdle;
      end
      StFill: begin
        lcg_d = lcg_next;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = StMix;
        end else begin
          cnt_d = idx_t'(cnt_q + 1'b1);
        end
      end
      StMix: begin
        lcg_d     = lcg_next;
        raddr_a   = cnt_q;
        wb_vld_d  = 1'b1;
        wb_addr_d = cnt_q;
        wb_and_d  = '1;
        wb_or_d   = (lcg_next > MsbThreshold) ? TopBit : '0;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = StDiag;
        end else begin
          cnt_d = idx_t'(cnt_q + 1'b1);
        end
      end
      StDiag: begin
        raddr_a   = diag_addr;
        wb_vld_d  = 1'b1;
        wb_addr_d = diag_addr;
        wb_and_d  = word_t'('1) >> diag_j;
        wb_or_d   = TopBit >> diag_j;
        if (diag_j == LastDiag) begin
          state_d = StDrain;
        end else begin
          cnt_d = idx_t'(cnt_q + 1'b1);
        end
      end
      StDrain: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // single write port: fill, draw write-back and reseed write-back never overlap
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = lcg_next;
    if (state_q == StFill) begin
      we = 1'b1;
    end else if (state_q == StDraw) begin
      we    = 1'b1;
      waddr = pos_q;
      wdata = draw_word;
    end else if (wb_vld_q) begin
      we    = 1'b1;
      waddr = wb_addr_q;
      wdata = (rdata_a & wb_and_q) | wb_or_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pos_q    <= '0;
      cnt_q    <= '0;
      lcg_q    <= '0;
      wb_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      lcg_q    <= lcg_d;
      wb_vld_q <= wb_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= wb_addr_d;
    wb_and_q  <= wb_and_d;
    wb_or_q   <= wb_or_d;
  end

  r250_ram #(
    .Width (WordBits),
    .Depth (TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (partner),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign busy           = (state_q != StIdle);
  assign valid_o        = (state_q == StDraw);
  assign random_value_o = draw_word;

  // a draw transfer yields its word in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !mode_i) |=> valid_o)
    else $error("draw result missing");

  // a reseed never yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i) |=> !valid_o)
    else $error("reseed produced a result");

  // draw position stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastIdx)
    else $error("draw position out of range");

  // reseed write-back only during the msb and diagonal passes and the final drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> (state_q == StMix || state_q == StDiag || state_q == StDrain))
    else $error("stray write-back");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench for r250_random_generator_core: reseeds and draws with random gaps,
// predicts every drawn word with its own copy of the table and checks each strobe
// depends on r250_pkg and the core rtl
module testbench;
  import r250_pkg::*;

  localparam int unsigned DiagStep    = 7;
  localparam int unsigned TotalItems  = 1350;
  localparam int unsigned MaxReported = 10;

  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } op_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = OP_DRAW;
  logic [31:0] seed_value_i = '0;
  logic        valid_o;
  logic [31:0] random_value_o;

  r250_random_generator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .seed_value_i   (seed_value_i),
    .valid_o        (valid_o),
    .random_value_o (random_value_o)
  );

  // predicted generator state
  word_t lag_words [TableDepth];
  idx_t  draw_pos;
  word_t lcg_state;

  word_t expected_words [$];
  int unsigned items_sent;
  int unsigned mismatch_count;
  int unsigned fail_count;
  int unsigned no_idle_left;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reseed_table(input word_t seed);
    word_t top;
    word_t keep;
    int unsigned k;
    lcg_state = seed;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      lcg_state = LcgMul * lcg_state + LcgAdd;
      lag_words[i] = lcg_state;
    end
    for (int unsigned i = 0; i < TableDepth; i++) begin
      lcg_state = LcgMul * lcg_state + LcgAdd;
      if (lcg_state > MsbThreshold) lag_words[i] |= TopBit;
    end
    // diagonal fix: word 7j+3 gets bit 31-j set and all higher bits cleared
    top  = TopBit;
    keep = '1;
    for (int unsigned j = 0; j < DiagCount; j++) begin
      k = DiagStep * j + DiagOffset;
      if (k < TableDepth) lag_words[k] = (lag_words[k] & keep) | top;
      keep = keep >> 1;
      top  = top >> 1;
    end
    draw_pos = '0;
  endfunction

  function automatic word_t draw_word();
    idx_t  partner;
    word_t w;
    partner = (draw_pos >= LagWrap) ? idx_t'(draw_pos - LagWrap) : idx_t'(draw_pos + LagShort);
    w = lag_words[draw_pos] ^ lag_words[partner];
    lag_words[draw_pos] = w;
    draw_pos = (draw_pos == LastIdx) ? idx_t'(0) : idx_t'(draw_pos + 1);
    return w;
  endfunction

  // one transfer; called just after a rising edge, returns at the accepting edge
  task automatic send_item(input op_e op, input word_t seed);
    int unsigned gap;
    bit          idle_seen;
    if (no_idle_left > 0) begin
      gap = 0;
      no_idle_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      gap = 0;
      no_idle_left = $urandom_range(10, 60);
    end else begin
      gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= op;
    seed_value_i <= seed;
    do begin
      @(negedge clk_i);
      idle_seen = !busy;
      @(posedge clk_i);
    end while (!idle_seen);
    items_sent++;
    if (op == OP_RESEED) reseed_table(seed);
    else expected_words.push_back(draw_word());
  endtask

  task automatic note_failure(input string what, input word_t exp_w, input word_t act_w);
    fail_count++;
    if (mismatch_count < MaxReported)
      $display("%0t: %s expected %08h got %08h", $realtime, what, exp_w, act_w);
    mismatch_count++;
  endtask

  // results are stable for the whole strobe cycle, so take them mid-cycle
  always @(negedge clk_i) begin
    word_t exp_w;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_words.size() == 0) begin
        note_failure("unexpected word", '0, random_value_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (random_value_o !== exp_w) note_failure("random_value", exp_w, random_value_o);
      end
    end
  end

  task automatic test_seed_extremes();
    word_t seeds [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    foreach (seeds[i]) begin
      send_item(OP_RESEED, seeds[i]);
      send_item(OP_DRAW, 32'h0000_0000);
      send_item(OP_DRAW, 32'hFFFF_FFFF);
      send_item(OP_DRAW, 32'h5555_AAAA);
    end
  endtask

  task automatic test_back_to_back_reseed();
    send_item(OP_RESEED, 32'hAAAA_5555);
    send_item(OP_RESEED, 32'h1234_5678);
    send_item(OP_DRAW, $urandom);
    send_item(OP_DRAW, $urandom);
  endtask

  // well-formed runs: a reseed then a burst of draws (at times none); first run long enough to wrap
  task automatic test_random_sequences();
    int unsigned n_draws;
    bit          first_run;
    word_t       seed;
    first_run = 1'b1;
    while (items_sent < TotalItems) begin
      case ($urandom_range(0, 7))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = $urandom;
      endcase
      send_item(OP_RESEED, seed);
      if (first_run) n_draws = $urandom_range(260, 600);
      else if ($urandom_range(0, 5) == 0) n_draws = 0;
      else n_draws = $urandom_range(1, 500);
      first_run = 1'b0;
      for (int unsigned i = 0; i < n_draws && items_sent < TotalItems; i++)
        send_item(OP_DRAW, $urandom);
    end
  endtask

  initial begin
    int unsigned waited;
    items_sent     = 0;
    mismatch_count = 0;
    fail_count     = 0;
    no_idle_left   = 0;
    draw_pos       = '0;
    lcg_state      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_seed_extremes();
    test_back_to_back_reseed();
    test_random_sequences();

    start <= 1'b0;
    waited = 0;
    while (expected_words.size() > 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (expected_words.size() > 0) begin
      $display("%0d drawn words never arrived", expected_words.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // worst case is every transfer a reseed with the longest gap, taken several times over
  initial begin
    #50ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/r250_pkg.sv
rtl/r250_ram.sv
rtl/r250_random_generator_core.sv
tb/testbench.sv
